@@ src/swm_pkg.sv @@
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the sliding window median filter
// Sample type, window sizing and the broadcast/neighbor link structs that
// tie the sorting cells together.
// ----------------------------------------------------------------------------
package swm_pkg;

  // Window and sample sizing
  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int IDX_W       = $clog2(MAX_WINDOW);
  localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
  localparam int LEN_W       = 7;
  localparam logic [LEN_W-1:0] RESET_LEN = LEN_W'(5);

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;
  typedef logic [IDX_W-1:0]              idx_t;
  typedef logic [CNT_W-1:0]              cnt_t;
  typedef logic [LEN_W-1:0]              len_t;

  // Broadcast to every cell for one update
  typedef struct packed {
    logic upd;   // load the next value this cycle
    logic full;  // window full: the oldest sample leaves
    smp_t smp;   // incoming sample
    smp_t thr;   // value of the sample that leaves
  } swm_bcast_t;

  // Value and "at or below the new sample" flag passed between neighbors
  typedef struct packed {
    smp_t val;
    logic le;
  } swm_link_t;

endpackage

@@ src/swm_cell.sv @@
// ----------------------------------------------------------------------------
// swm_cell: one slot of the sorted window
// Holds one sample. On an update it closes the gap of a removed entry and
// opens one for the new sample, looking only at its two neighbors.
// ----------------------------------------------------------------------------
module swm_cell (
  input  logic               clk,
  input  swm_pkg::swm_bcast_t bc,
  input  logic               cell_valid,  // slot holds a live sample
  input  swm_pkg::swm_link_t  from_right,  // right neighbor: stored value
  input  swm_pkg::swm_link_t  from_left,   // left neighbor: value after removal
  output swm_pkg::swm_link_t  to_left,
  output swm_pkg::swm_link_t  to_right,
  output swm_pkg::smp_t       val
);
  import swm_pkg::*;

  smp_t val_r;
  smp_t val_nxt;
  logic le;
  logic del;
  smp_t post_val;
  logic post_le;

  // Local compares: stays at or below the new sample, sits at or above the
  // leaving sample (equal values keep arrival order, oldest first)
  assign le  = cell_valid && !(bc.smp < val_r);
  assign del = bc.full && cell_valid && !(val_r < bc.thr);

  // Array after the leaving entry is removed
  assign post_val = del ? from_right.val : val_r;
  assign post_le  = del ? from_right.le  : le;

  // Insert: keep, take the new sample, or take the left neighbor
  always_comb begin
    if (post_le) begin
      val_nxt = post_val;
    end else if (from_left.le) begin
      val_nxt = bc.smp;
    end else begin
      val_nxt = from_left.val;
    end
  end

  always_ff @(posedge clk) begin
    if (bc.upd) begin
      val_r <= val_nxt;
    end
  end

  assign to_left  = '{val: val_r, le: le};
  assign to_right = '{val: post_val, le: post_le};
  assign val      = val_r;

endmodule

@@ src/swm_row.sv @@
// ----------------------------------------------------------------------------
// swm_row: the row of sorting cells
// Chains MAX_WINDOW cells and picks the median slot with an AND-OR tap.
// ----------------------------------------------------------------------------
module swm_row (
  input  logic                clk,
  input  swm_pkg::swm_bcast_t bc,
  input  swm_pkg::cnt_t       fill,     // live slots before this update
  input  swm_pkg::idx_t       mid_idx,  // slot of the lower median
  output swm_pkg::smp_t       median
);
  import swm_pkg::*;

  swm_link_t lnk_l [MAX_WINDOW];  // cell i -> cell i-1
  swm_link_t lnk_r [MAX_WINDOW];  // cell i -> cell i+1
  smp_t      vals  [MAX_WINDOW];
  smp_t      taps  [MAX_WINDOW];

  genvar i;
  generate
    for (i = 0; i < MAX_WINDOW; i++) begin : g_cell
      swm_link_t from_r;
      swm_link_t from_l;
      logic      cv;

      assign cv = fill > CNT_W'(i);

      // Ends of the row: nothing live beyond the last cell, and the first
      // cell sees an empty "everything below" on its left
      if (i == MAX_WINDOW - 1) begin : g_last
        assign from_r = '{val: '0, le: 1'b0};
      end else begin : g_mid
        assign from_r = lnk_l[i+1];
      end
      if (i == 0) begin : g_first
        assign from_l = '{val: '0, le: 1'b1};
      end else begin : g_rest
        assign from_l = lnk_r[i-1];
      end

      swm_cell u_cell (
        .clk        (clk),
        .bc         (bc),
        .cell_valid (cv),
        .from_right (from_r),
        .from_left  (from_l),
        .to_left    (lnk_l[i]),
        .to_right   (lnk_r[i]),
        .val        (vals[i])
      );

      assign taps[i] = (mid_idx == IDX_W'(i)) ? vals[i] : '0;
    end
  endgenerate

  // Median tap: one-hot select folded with OR
  always_comb begin
    median = '0;
    for (int k = 0; k < MAX_WINDOW; k++) begin
      median = median | taps[k];
    end
  end

endmodule

@@ src/sliding_window_median.sv @@
// ----------------------------------------------------------------------------
// sliding_window_median: lower median over a sliding window of samples
// Arrival ring plus a row of sorting cells kept in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries in_sample and in_restart. A
//   restart empties the window before its sample is taken in.
//   Output channel out_valid/out_ready carries out_median, the element of
//   rank (L-1)/2 of the last L samples, L = cfg_window_len held to 1..64.
//   Nothing comes out until L samples have arrived since reset, restart or
//   a configuration write.
//   cfg_wr_en/cfg_window_len writes the window length and empties the
//   window; write it only while the block is idle.
//   A sample updates the cell row when it transfers; its median then passes
//   through the output register. Throughput: one sample per cycle while the
//   receiver keeps up; the ring prefetches the leaving sample in the same cycle.
//   When the receiver stalls, one result waits in the output register and
//   one more sample is taken; then in_ready drops until out_ready returns.
//   Reset (rst_n low, synchronous) sets the length to 5 and empties the
//   window; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sliding_window_median (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  swm_pkg::smp_t       in_sample,
  input  logic                in_restart,
  output logic                out_valid,
  input  logic                out_ready,
  output swm_pkg::smp_t       out_median,
  input  logic                cfg_wr_en,
  input  swm_pkg::len_t       cfg_window_len
);
  import swm_pkg::*;

  len_t wlen_r;
  cnt_t fill_r, fill_nxt;
  idx_t ptr_r, ptr_nxt;
  logic pend_r, pend_nxt;
  logic out_valid_r, out_valid_nxt;
  smp_t out_median_r;
  smp_t thr_r;

  logic [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];

  cnt_t len;
  idx_t mid_idx;
  cnt_t fill_eff;
  idx_t ptr_eff;
  cnt_t ptr_inc;
  logic full;
  logic emit;
  logic acc;
  logic slot_free;
  idx_t wr_addr;
  smp_t row_median;
  swm_bcast_t bc;

  // Effective window length and median slot
  always_comb begin
    if (wlen_r == '0) begin
      len = CNT_W'(1);
    end else if (int'(wlen_r) > MAX_WINDOW) begin
      len = CNT_W'(MAX_WINDOW);
    end else begin
      len = CNT_W'(wlen_r);
    end
  end
  assign mid_idx = IDX_W'((len - CNT_W'(1)) >> 1);

  // Handshake
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = !pend_r || slot_free;
  assign acc       = in_valid && in_ready;

  // Fill and ring pointer bookkeeping for the item on the input
  always_comb begin
    fill_eff = (in_restart || fill_r > len) ? '0 : fill_r;
    full     = fill_eff == len;
    ptr_eff  = (CNT_W'(ptr_r) >= len) ? '0 : ptr_r;
    ptr_inc  = CNT_W'(ptr_eff) + CNT_W'(1);
    if (full) begin
      wr_addr  = ptr_eff;
      fill_nxt = fill_eff;
      ptr_nxt  = (ptr_inc == len) ? '0 : IDX_W'(ptr_inc);
      emit     = 1'b1;
    end else begin
      wr_addr  = IDX_W'(fill_eff);
      fill_nxt = fill_eff + CNT_W'(1);
      ptr_nxt  = '0;
      emit     = (fill_eff + CNT_W'(1)) == len;
    end
  end

  // Arrival ring; read of the next leaving sample, bypassed when it is the
  // slot written now
  always_ff @(posedge clk) begin
    if (acc) begin
      ring_mem[wr_addr] <= in_sample;
      if (ptr_nxt == wr_addr) begin
        thr_r <= in_sample;
      end else begin
        thr_r <= smp_t'(ring_mem[ptr_nxt]);
      end
    end
  end

  // Sorted cell row
  assign bc = '{upd: acc, full: full, smp: in_sample, thr: thr_r};

  swm_row u_row (
    .clk     (clk),
    .bc      (bc),
    .fill    (fill_eff),
    .mid_idx (mid_idx),
    .median  (row_median)
  );

  // Result pending / output register next state
  always_comb begin
    if (acc) begin
      pend_nxt = emit;
    end else if (slot_free) begin
      pend_nxt = 1'b0;
    end else begin
      pend_nxt = pend_r;
    end
    if (pend_r && slot_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r      <= RESET_LEN;
      fill_r      <= '0;
      ptr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        wlen_r <= cfg_window_len;
        fill_r <= '0;
        ptr_r  <= '0;
      end else if (acc) begin
        fill_r <= fill_nxt;
        ptr_r  <= ptr_nxt;
      end
    end
  end

  // Output data register
  always_ff @(posedge clk) begin
    if (pend_r && slot_free) begin
      out_median_r <= row_median;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_median = out_median_r;

endmodule

@@ tb/sliding_window_median_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_tb: self-checking bench for the lower median filter
// Streams signed samples with restarts, changes the window length between
// phases, predicts each median from its own copy of the window, and checks
// every output transfer in order. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module sliding_window_median_tb;
  import swm_pkg::*;

  localparam int   SETTLE_CYCLES = 4;   // quiet wait that covers the output latency
  localparam smp_t SMP_MIN       = smp_t'(32'sh8000_0000);
  localparam smp_t SMP_MAX       = smp_t'(32'sh7fff_ffff);

  // Stimulus operations queued for the driver
  typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_DRAIN} op_kind_t;
  typedef struct {
    op_kind_t kind;
    smp_t     sample;
    logic     restart;
    len_t     len;
  } stim_op_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  smp_t in_sample = '0;
  logic in_restart = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  smp_t out_median;
  logic cfg_wr_en = 1'b0;
  len_t cfg_window_len = RESET_LEN;

  stim_op_t stim_q[$];
  smp_t     median_q[$];
  int       errors = 0;
  int       item_total = 0;
  logic     drv_done = 1'b0;

  // Predictor state
  smp_t win_ring[MAX_WINDOW];
  smp_t win_sorted[MAX_WINDOW];
  int   win_fill = 0;
  int   win_oldest = 0;
  len_t win_len = RESET_LEN;

  // Driver and monitor bookkeeping
  int   in_gap = 0, in_burst = 0, quiet = 0;
  int   out_gap = 0, out_burst = 0;
  logic nxt_valid, nxt_cfg, nxt_ready;

  sliding_window_median dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_median     (out_median),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_window_len (cfg_window_len)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Window model
  // ---------------------------------------------------------------------------
  function automatic int span_of(input len_t v);
    if (v == 0) return 1;
    if (v > MAX_WINDOW) return MAX_WINDOW;
    return int'(v);
  endfunction

  task automatic sorted_insert(input smp_t v, input int count);
    int i;
    i = count;
    while (i > 0 && v < win_sorted[i-1]) begin
      win_sorted[i] = win_sorted[i-1];
      i--;
    end
    win_sorted[i] = v;
  endtask

  // drop exactly one entry equal to v
  task automatic sorted_remove(input smp_t v, input int count);
    int i;
    i = 0;
    while (i < count && win_sorted[i] != v) i++;
    for (; i + 1 < count; i++) win_sorted[i] = win_sorted[i+1];
  endtask

  task automatic predict_median(input smp_t s, input logic rs);
    int span, p;
    span = span_of(win_len);
    if (rs) begin
      win_fill = 0;
      win_oldest = 0;
    end
    if (win_fill < span) begin
      win_ring[win_fill] = s;
      sorted_insert(s, win_fill);
      win_fill++;
      win_oldest = 0;
      if (win_fill < span) return;
    end else begin
      p = (win_oldest >= span) ? 0 : win_oldest;
      sorted_remove(win_ring[p], span);
      sorted_insert(s, span - 1);
      win_ring[p] = s;
      p++;
      win_oldest = (p >= span) ? 0 : p;
    end
    median_q = {median_q, win_sorted[(span - 1) / 2]};
  endtask

  task automatic set_window(input len_t v);
    win_len = v;
    win_fill = 0;
    win_oldest = 0;
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // idle draw: mostly 0..18, with runs of back-to-back transfers
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) burst = $urandom_range(20, 60);
    return $urandom_range(0, 18);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  function automatic void push_item(input smp_t s, input logic rs);
    stim_op_t op;
    op.kind = OP_ITEM;
    op.sample = s;
    op.restart = rs;
    op.len = '0;
    stim_q = {stim_q, op};
    item_total++;
  endfunction

  function automatic void push_cfg(input len_t v);
    stim_op_t op;
    op.kind = OP_CFG;
    op.sample = '0;
    op.restart = 1'b0;
    op.len = v;
    stim_q = {stim_q, op};
  endfunction

  function automatic void push_drain();
    stim_op_t op;
    op.kind = OP_DRAIN;
    op.sample = '0;
    op.restart = 1'b0;
    op.len = '0;
    stim_q = {stim_q, op};
  endfunction

  // extremes, small values for duplicates, full-range values
  function automatic smp_t rand_sample();
    case ($urandom_range(0, 9))
      0:       return SMP_MIN;
      1:       return SMP_MAX;
      2, 3, 4: return smp_t'(int'($urandom_range(0, 8)) - 4);
      default: return smp_t'($urandom());
    endcase
  endfunction

  function automatic len_t rand_len();
    case ($urandom_range(0, 9))
      0:       return len_t'(0);
      1:       return len_t'(127);
      2:       return len_t'(MAX_WINDOW);
      3:       return len_t'($urandom_range(65, 126));
      4:       return len_t'($urandom_range(17, 63));
      default: return len_t'($urandom_range(1, 16));
    endcase
  endfunction

  initial begin
    len_t v;
    int   n;
    // reset length 5: extremes fill the window, then duplicates slide in
    push_item(SMP_MIN, 1'b0);
    push_item(SMP_MAX, 1'b0);
    push_item(smp_t'(0), 1'b0);
    push_item(smp_t'(-1), 1'b0);
    push_item(smp_t'(1), 1'b0);
    push_item(smp_t'(1), 1'b0);
    push_item(smp_t'(1), 1'b0);
    push_item(smp_t'(-1), 1'b0);
    // restart, then a partial window that yields nothing
    push_item(smp_t'(7), 1'b1);
    push_item(smp_t'(3), 1'b0);
    push_item(smp_t'(9), 1'b0);
    push_drain();
    // zero length acts as one
    push_cfg(len_t'(0));
    push_item(SMP_MAX, 1'b0);
    push_item(SMP_MIN, 1'b0);
    push_item(SMP_MIN, 1'b1);
    // even window: lower median
    push_cfg(len_t'(2));
    push_item(smp_t'(5), 1'b0);
    push_item(smp_t'(5), 1'b0);
    push_item(smp_t'(-5), 1'b0);
    push_item(SMP_MAX, 1'b0);
    // over-range length saturates to the maximum window
    push_cfg(len_t'(127));
    n = MAX_WINDOW + 4;
    for (int i = 0; i < n; i++) push_item(rand_sample(), 1'b0);

    // random phases, each with its own window length
    while (item_total < 550) begin
      v = rand_len();
      push_cfg(v);
      n = span_of(v) + ((span_of(v) > 16) ? $urandom_range(20, 40) : $urandom_range(10, 60));
      for (int i = 0; i < n; i++) begin
        push_item(rand_sample(), ($urandom_range(0, 29) == 0));
        if ($urandom_range(0, 79) == 0) push_drain();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input driver
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_wr_en <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      nxt_cfg = 1'b0;
      if (in_valid && in_ready) begin
        predict_median(in_sample, in_restart);
        nxt_valid = 1'b0;
        in_gap = draw_gap(in_burst);
        quiet = 0;
      end
      if (!nxt_valid) begin
        if (stim_q.size() == 0) begin
          drv_done = 1'b1;
        end else if (stim_q[0].kind == OP_ITEM) begin
          if (in_gap > 0) begin
            in_gap--;
          end else begin
            in_sample <= stim_q[0].sample;
            in_restart <= stim_q[0].restart;
            nxt_valid = 1'b1;
            void'(stim_q.pop_front());
          end
        end else if (median_q.size() != 0 || out_valid) begin
          quiet = 0;
        end else if (quiet < SETTLE_CYCLES) begin
          // items that emit nothing may still be in the pipeline
          quiet++;
        end else begin
          if (stim_q[0].kind == OP_CFG) begin
            cfg_window_len <= stim_q[0].len;
            nxt_cfg = 1'b1;
            set_window(stim_q[0].len);
          end
          void'(stim_q.pop_front());
          quiet = 0;
        end
      end
      in_valid <= nxt_valid;
      cfg_wr_en <= nxt_cfg;
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor and checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      nxt_ready = out_ready;
      if (out_valid && out_ready) begin
        if (median_q.size() == 0) begin
          report_mismatch($sformatf("unexpected median %0d", out_median));
        end else begin
          if (out_median !== median_q[0])
            report_mismatch($sformatf("median got %0d expected %0d", out_median, median_q[0]));
          void'(median_q.pop_front());
        end
        nxt_ready = 1'b0;
        out_gap = draw_gap(out_burst);
      end
      if (!nxt_ready) begin
        if (out_gap > 0) out_gap--;
        else nxt_ready = 1'b1;
      end
      out_ready <= nxt_ready;
    end
  end

  // ---------------------------------------------------------------------------
  // Reset, end of run
  // ---------------------------------------------------------------------------
  initial begin
    int k;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wait (drv_done);
    k = 0;
    while (k < 2000 && median_q.size() != 0) begin
      @(posedge clk);
      k++;
    end
    if (median_q.size() != 0)
      report_mismatch($sformatf("%0d medians never arrived", median_q.size()));
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ sliding_window_median.f @@
src/swm_pkg.sv
src/swm_cell.sv
src/swm_row.sv
src/sliding_window_median.sv
tb/sliding_window_median_tb.sv
